>>> rtl/irst_pkg.sv
// ----------------------------------------------------------------------------
// irst_pkg
// Shared types, constants and the address mix function of the reputation
// score table.
// ----------------------------------------------------------------------------
package irst_pkg;

    localparam int BUCKETS_DEFAULT = 1024;
    localparam int WAYS_DEFAULT    = 4;

    localparam int ADDR_W   = 32;
    localparam int SCORE_W  = 7;
    localparam int MASK_W   = 32;
    localparam int DAMAGE_W = 9;
    localparam int KIND_W   = 5;
    localparam int REC_W    = 8;
    localparam int COUNT_W  = 13;

    localparam logic [SCORE_W-1:0] FULL_SCORE = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;

    // Six mix rounds of the bucket hash
    localparam logic [2:0] HASH_ROUNDS = 3'd6;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DECAY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // One stored slot
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  address;
        logic [SCORE_W-1:0] score;
        logic [MASK_W-1:0]  mask;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic hash_go;
        logic mod_go;
        logic scan_go;
        logic decay_go;
        logic clear_go;
        logic result_go;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hash_last;
        logic mod_last;
        logic scan_last;
        logic sweep_last;
    } status_t;

    // One round of the integer mix hash
    function automatic logic [31:0] hash_round(input logic [31:0] h, input logic [2:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                3'd0:    r = (h + 32'h7ed55d16) + (h << 12);
                3'd1:    r = (h ^ 32'hc761c23c) ^ (h >> 19);
                3'd2:    r = (h + 32'h165667b1) + (h << 5);
                3'd3:    r = (h + 32'hd3a2646c) ^ (h << 9);
                3'd4:    r = (h + 32'hfd7046c5) + (h << 3);
                3'd5:    r = (h ^ 32'hb55a4f09) ^ (h >> 16);
                default: r = h;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/irst_ram.sv
// ----------------------------------------------------------------------------
// irst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module irst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/irst_datapath.sv
// ----------------------------------------------------------------------------
// irst_datapath
// Hash, bucket reduction, way scan, decay sweep and result registers.
// ----------------------------------------------------------------------------
module irst_datapath #(
    parameter int BUCKETS = irst_pkg::BUCKETS_DEFAULT,
    parameter int WAYS    = irst_pkg::WAYS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  irst_pkg::cmd_t                     cmd,
    output irst_pkg::status_t                  status,
    input  logic [1:0]                         operation,
    input  logic [irst_pkg::ADDR_W-1:0]        address,
    input  logic signed [irst_pkg::DAMAGE_W-1:0] damage,
    input  logic [irst_pkg::KIND_W-1:0]        threat_kind,
    input  logic [irst_pkg::REC_W-1:0]         recovery,
    output logic [irst_pkg::SCORE_W-1:0]       score_out,
    output logic                               was_known,
    output logic                               bucket_full,
    output logic [irst_pkg::MASK_W-1:0]        threat_mask,
    output logic [irst_pkg::COUNT_W-1:0]       removed_count
);

    import irst_pkg::*;

    localparam int SLOTS      = BUCKETS * WAYS;
    localparam int SW         = $clog2(SLOTS);
    localparam int BW         = $clog2(BUCKETS);
    localparam int WIW        = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit IS_POW2    = ((1 << BW) == BUCKETS);
    localparam int MOD_CYCLES = IS_POW2 ? 1 : 8;

    // Captured item
    op_t                        op_reg;
    logic [ADDR_W-1:0]          key_reg;
    logic signed [DAMAGE_W-1:0] damage_reg;
    logic [KIND_W-1:0]          kind_reg;
    logic [REC_W-1:0]           rec_reg;

    // Hash and reduction
    logic [31:0]   h_reg;
    logic [2:0]    hash_cnt_reg;
    logic [2:0]    mod_cnt_reg;
    logic [BW-1:0] bucket_reg;
    logic [BW-1:0] bucket_next;

    // Scan state
    logic [WIW-1:0]     way_cnt_reg;
    logic               scan_pend_reg;
    logic [WIW-1:0]     way_pend_reg;
    logic               hit_reg;
    logic [WIW-1:0]     hit_way_reg;
    logic [SCORE_W-1:0] hit_score_reg;
    logic [MASK_W-1:0]  hit_mask_reg;
    logic               spare_reg;
    logic [WIW-1:0]     spare_way_reg;

    // Sweep state
    logic [SW-1:0]      slot_cnt_reg;
    logic               decay_pend_reg;
    logic [SW-1:0]      slot_pend_reg;
    logic [COUNT_W-1:0] removed_reg;

    // RAM ports
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    entry_t        rd_data;

    // Commit values
    logic               res_known;
    logic               res_full;
    logic [SCORE_W-1:0] res_score;
    logic [MASK_W-1:0]  res_mask;
    logic               commit_wr;
    logic [WIW-1:0]     commit_way;
    logic signed [10:0] upd_sum;
    logic [8:0]         dec_sum;
    logic [MASK_W-1:0]  kind_bit;

    function automatic logic [SW-1:0] slot_of(input logic [BW-1:0] b, input logic [WIW-1:0] w);
        begin
            return SW'(int'(b) * WAYS + int'(w));
        end
    endfunction

    // Bucket reduction: mask for a power of two, else four restoring steps a cycle
    always_comb
    begin
        logic [BW:0] t;
        bucket_next = bucket_reg;
        t           = '0;
        if (IS_POW2)
        begin
            bucket_next = h_reg[BW-1:0];
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                t = {bucket_next, h_reg[31-k]};
                if (t >= (BW+1)'(BUCKETS))
                begin
                    t = t - (BW+1)'(BUCKETS);
                end
                bucket_next = t[BW-1:0];
            end
        end
    end

    assign status.hash_last  = (hash_cnt_reg == HASH_ROUNDS - 3'd1);
    assign status.mod_last   = (mod_cnt_reg == 3'(MOD_CYCLES - 1));
    assign status.scan_last  = (way_cnt_reg == WIW'(WAYS - 1));
    assign status.sweep_last = (slot_cnt_reg == SW'(SLOTS - 1));

    // Result of the current item
    always_comb
    begin
        kind_bit   = MASK_W'(1) << kind_reg;
        upd_sum    = 11'(signed'({4'b0, (hit_reg ? hit_score_reg : FULL_SCORE)}))
                     - 11'(damage_reg);
        res_known  = 1'b0;
        res_full   = 1'b0;
        res_score  = '0;
        res_mask   = '0;
        commit_wr  = 1'b0;
        commit_way = hit_reg ? hit_way_reg : spare_way_reg;
        case (op_reg)
            OP_LOOKUP:
            begin
                res_known = hit_reg;
                res_score = hit_reg ? hit_score_reg : FULL_SCORE;
                res_mask  = hit_reg ? hit_mask_reg : '0;
            end
            OP_UPDATE:
            begin
                res_known = hit_reg;
                if (upd_sum < 0)
                begin
                    res_score = '0;
                end
                else if (upd_sum > 11'sd100)
                begin
                    res_score = FULL_SCORE;
                end
                else
                begin
                    res_score = upd_sum[SCORE_W-1:0];
                end
                res_mask  = (hit_reg ? hit_mask_reg : '0) | kind_bit;
                res_full  = !hit_reg && !spare_reg;
                commit_wr = hit_reg || spare_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Decay of one returned slot
    assign dec_sum = {2'b0, rd_data.score} + {1'b0, rec_reg};

    // RAM port selection
    always_comb
    begin
        rd_en   = cmd.scan_go || cmd.decay_go;
        rd_addr = cmd.decay_go ? slot_cnt_reg : slot_of(bucket_reg, way_cnt_reg);
        wr_en   = 1'b0;
        wr_addr = slot_cnt_reg;
        wr_data = '0;
        if (cmd.clear_go)
        begin
            wr_en = 1'b1;
        end
        else if (decay_pend_reg && rd_data.valid)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_pend_reg;
            wr_data = rd_data;
            if (dec_sum >= 9'd100)
            begin
                wr_data.valid = 1'b0;
            end
            else
            begin
                wr_data.score = dec_sum[SCORE_W-1:0];
            end
        end
        else if (cmd.result_go && commit_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(bucket_reg, commit_way);
            wr_data = '{valid: 1'b1, address: key_reg, score: res_score, mask: res_mask};
        end
    end

    irst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_cnt_reg   <= '0;
            mod_cnt_reg    <= '0;
            way_cnt_reg    <= '0;
            slot_cnt_reg   <= '0;
            scan_pend_reg  <= 1'b0;
            decay_pend_reg <= 1'b0;
            hit_reg        <= 1'b0;
            spare_reg      <= 1'b0;
            removed_reg    <= '0;
        end
        else
        begin
            scan_pend_reg  <= cmd.scan_go;
            decay_pend_reg <= cmd.decay_go;
            if (cmd.capture)
            begin
                hash_cnt_reg <= '0;
                mod_cnt_reg  <= '0;
                way_cnt_reg  <= '0;
                hit_reg      <= 1'b0;
                spare_reg    <= 1'b0;
                removed_reg  <= '0;
            end
            if (cmd.hash_go)
            begin
                hash_cnt_reg <= hash_cnt_reg + 3'd1;
            end
            if (cmd.mod_go)
            begin
                mod_cnt_reg <= mod_cnt_reg + 3'd1;
            end
            if (cmd.scan_go)
            begin
                way_cnt_reg <= way_cnt_reg + WIW'(1);
            end
            if (cmd.clear_go || cmd.decay_go)
            begin
                slot_cnt_reg <= (slot_cnt_reg == SW'(SLOTS - 1)) ? '0 : slot_cnt_reg + SW'(1);
            end
            // way evaluation
            if (scan_pend_reg)
            begin
                if (rd_data.valid && rd_data.address == key_reg && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!rd_data.valid && !spare_reg)
                begin
                    spare_reg <= 1'b1;
                end
            end
            // removal tally
            if (decay_pend_reg && rd_data.valid && dec_sum >= 9'd100
                && removed_reg != COUNT_MAX)
            begin
                removed_reg <= removed_reg + COUNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_t'(operation);
            key_reg    <= address;
            damage_reg <= damage;
            kind_reg   <= threat_kind;
            rec_reg    <= recovery;
            h_reg      <= address;
            bucket_reg <= '0;
        end
        if (cmd.hash_go)
        begin
            h_reg <= hash_round(h_reg, hash_cnt_reg);
        end
        if (cmd.mod_go)
        begin
            bucket_reg <= bucket_next;
            h_reg      <= h_reg << 4;
        end
        if (cmd.scan_go)
        begin
            way_pend_reg <= way_cnt_reg;
        end
        if (cmd.decay_go)
        begin
            slot_pend_reg <= slot_cnt_reg;
        end
        if (scan_pend_reg)
        begin
            if (rd_data.valid && rd_data.address == key_reg && !hit_reg)
            begin
                hit_way_reg   <= way_pend_reg;
                hit_score_reg <= rd_data.score;
                hit_mask_reg  <= rd_data.mask;
            end
            if (!rd_data.valid && !spare_reg)
            begin
                spare_way_reg <= way_pend_reg;
            end
        end
        if (cmd.result_go)
        begin
            score_out     <= res_score;
            was_known     <= res_known;
            bucket_full   <= res_full;
            threat_mask   <= res_mask;
            removed_count <= (op_reg == OP_DECAY) ? removed_reg : '0;
        end
    end

endmodule

>>> rtl/irst_ctrl.sv
// ----------------------------------------------------------------------------
// irst_ctrl
// Sequencer: clearing pass, hash, reduction, way scan or decay sweep, and
// the hand-off of each result word.
// ----------------------------------------------------------------------------
module irst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    output logic              out_valid,
    input  logic              out_stall,
    output irst_pkg::cmd_t    cmd,
    input  irst_pkg::status_t status
);

    import irst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_SCAN,
        S_DECAY,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_go = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (op_t'(operation))
                        OP_LOOKUP, OP_UPDATE: state_next = S_HASH;
                        OP_DECAY:             state_next = S_DECAY;
                        OP_NONE:              state_next = S_FINISH;
                    endcase
                end
            end
            S_HASH:
            begin
                cmd.hash_go = 1'b1;
                if (status.hash_last)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_go = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_go = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_DECAY:
            begin
                cmd.decay_go = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.result_go = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.result_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A result is only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_go |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a waiting word");

    // An accepted word always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted word did not start work");

    // No table access while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(cmd.scan_go || cmd.decay_go || cmd.clear_go))
        else $error("table access while idle");

    // Result valid rises only after a finish step
    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result valid without a finished word");

endmodule

>>> rtl/ip_reputation_score_table.sv
// ----------------------------------------------------------------------------
// ip_reputation_score_table
// Hashed IPv4 reputation score table: lookup, update with damage, decay.
//
//  channel | handshake          | fields
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | operation address damage threat_kind recovery
//  out     | out_valid/out_stall| score_out was_known bucket_full threat_mask
//          |                    | removed_count
//
//  Lookup/update: six serial hash rounds, a bucket reduction (mask with
//  power-of-two BUCKETS, else restoring steps) and one RAM read per way.
//  Decay: all BUCKETS*WAYS slots read, one per cycle; valid ones rewritten.
//  Reset: a clearing pass over every slot, input stalled meanwhile.
//  One word in flight; out_stall holds the finished word, input accepted
//  again as soon as the word is registered.
// ----------------------------------------------------------------------------
module ip_reputation_score_table #(
    parameter int BUCKETS = irst_pkg::BUCKETS_DEFAULT,
    parameter int WAYS    = irst_pkg::WAYS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           operation,
    input  logic [irst_pkg::ADDR_W-1:0]          address,
    input  logic signed [irst_pkg::DAMAGE_W-1:0] damage,
    input  logic [irst_pkg::KIND_W-1:0]          threat_kind,
    input  logic [irst_pkg::REC_W-1:0]           recovery,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [irst_pkg::SCORE_W-1:0]         score_out,
    output logic                                 was_known,
    output logic                                 bucket_full,
    output logic [irst_pkg::MASK_W-1:0]          threat_mask,
    output logic [irst_pkg::COUNT_W-1:0]         removed_count
);

    import irst_pkg::*;

    cmd_t    cmd;
    status_t status;

    irst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    irst_datapath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .address       (address),
        .damage        (damage),
        .threat_kind   (threat_kind),
        .recovery      (recovery),
        .score_out     (score_out),
        .was_known     (was_known),
        .bucket_full   (bucket_full),
        .threat_mask   (threat_mask),
        .removed_count (removed_count)
    );

endmodule
